### rtl/assert_macros.svh
// Assertion helpers used by the checker.
// Each use samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every sampled edge.
`define SOM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SOM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/som_bmu_pkg.sv
package som_bmu_pkg;

  localparam int MAX_NEURONS_DEF  = 128;
  localparam int MAX_FEATURES_DEF = 128;
  localparam int VALUE_BITS_DEF   = 16;

  localparam int INDEX_BITS   = 7;
  localparam int CFG_BITS     = 8;
  localparam int CFG_IDX_BITS = 1;
  localparam int WINNER_BITS  = 7;
  localparam int DIST_BITS    = 23;

  localparam logic [DIST_BITS-1:0] DIST_MAX       = '1;
  localparam logic [CFG_BITS-1:0]  NEURONS_RESET  = 8'd100;
  localparam logic [CFG_BITS-1:0]  FEATURES_RESET = 8'd118;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NEURONS  = 1'b0,
    CFG_FEATURES = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_WEIGHT = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic wr_weight;
    logic wr_sample;
    logic start;
    logic step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic last_feature;
    logic last_neuron;
  } dp_status_t;

endpackage

### rtl/som_bmu_if.sv
interface som_bmu_item_if import som_bmu_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [INDEX_BITS-1:0]        neuron_index;
  logic [INDEX_BITS-1:0]        feature_index;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, operation, neuron_index, feature_index, value, input ready);
  modport sink   (input valid, operation, neuron_index, feature_index, value, output ready);
endinterface

interface som_bmu_result_if import som_bmu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [WINNER_BITS-1:0] winner;
  logic [DIST_BITS-1:0]   min_distance;

  modport source (output valid, winner, min_distance, input ready);
  modport sink   (input valid, winner, min_distance, output ready);
endinterface

interface som_bmu_cfg_if import som_bmu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] reg_index;
  logic [CFG_BITS-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### rtl/som_bmu_ram.sv
module som_bmu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/som_bmu_ctrl.sv
module som_bmu_ctrl import som_bmu_pkg::*; #(
  parameter int MAX_NEURONS  = MAX_NEURONS_DEF,
  parameter int MAX_FEATURES = MAX_FEATURES_DEF,
  localparam int NW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1,
  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  logic                    item_valid_i,
  output logic                    item_ready_o,
  input  logic                    item_op_i,
  input  logic [INDEX_BITS-1:0]   item_ni_i,
  input  logic [INDEX_BITS-1:0]   item_fi_i,
  output logic                    result_valid_o,
  input  logic                    result_ready_i,
  output dp_cmd_t                 cmd_o,
  input  dp_status_t              status_i,
  output logic [NW-1:0]           neuron_last_o,
  output logic [FW-1:0]           feature_last_o
);

  ctrl_state_e         state_q, state_d;
  logic [CFG_BITS-1:0] neurons_q, features_q;
  logic                result_valid_q, result_valid_d;
  logic                accept, ni_ok, fi_ok, is_sample, trigger, out_free;

  // Effective counts: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (neurons_q == '0) begin
      neuron_last_o = '0;
    end else if (32'(neurons_q) > 32'(MAX_NEURONS)) begin
      neuron_last_o = NW'(MAX_NEURONS - 1);
    end else begin
      neuron_last_o = NW'(neurons_q - 8'd1);
    end
    if (features_q == '0) begin
      feature_last_o = '0;
    end else if (32'(features_q) > 32'(MAX_FEATURES)) begin
      feature_last_o = FW'(MAX_FEATURES - 1);
    end else begin
      feature_last_o = FW'(features_q - 8'd1);
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neurons_q  <= NEURONS_RESET;
      features_q <= FEATURES_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_NEURONS:  neurons_q  <= cfg_data_i;
        CFG_FEATURES: features_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Take words only between searches.
  assign item_ready_o = (state_q == ST_IDLE);

  assign accept    = item_valid_i && item_ready_o;
  assign ni_ok     = 32'(item_ni_i) < 32'(MAX_NEURONS);
  assign fi_ok     = 32'(item_fi_i) < 32'(MAX_FEATURES);
  assign is_sample = (item_op_i == OP_SAMPLE);
  assign trigger   = accept && is_sample && fi_ok && (FW'(item_fi_i) == feature_last_o);
  assign out_free  = !result_valid_q || result_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (trigger) state_d = ST_RUN;
      ST_RUN:   if (status_i.last_neuron && status_i.last_feature) state_d = ST_DRAIN;
      ST_DRAIN: if (!status_i.busy) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.wr_weight = accept && !is_sample && ni_ok && fi_ok;
        cmd_o.wr_sample = accept && is_sample && fi_ok;
        cmd_o.start     = trigger;
      end
      ST_RUN:   cmd_o.step = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      result_valid_d = 1'b1;
    end else if (result_ready_i) begin
      result_valid_d = 1'b0;
    end else begin
      result_valid_d = result_valid_q;
    end
  end

  assign result_valid_o = result_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= result_valid_d;
    end
  end

endmodule

### rtl/som_bmu_datapath.sv
module som_bmu_datapath import som_bmu_pkg::*; #(
  parameter int MAX_NEURONS  = MAX_NEURONS_DEF,
  parameter int MAX_FEATURES = MAX_FEATURES_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF,
  localparam int NW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1,
  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dp_cmd_t                      cmd_i,
  output dp_status_t                   status_o,
  input  logic [NW-1:0]                neuron_last_i,
  input  logic [FW-1:0]                feature_last_i,
  input  logic [INDEX_BITS-1:0]        item_ni_i,
  input  logic [INDEX_BITS-1:0]        item_fi_i,
  input  logic signed [VALUE_BITS-1:0] item_value_i,
  output logic [WINNER_BITS-1:0]       winner_o,
  output logic [DIST_BITS-1:0]         min_distance_o
);

  localparam int VB     = VALUE_BITS;
  localparam int DW     = VB + $clog2(MAX_FEATURES + 1);
  localparam int CW     = (DW > DIST_BITS) ? DW : DIST_BITS;
  localparam int WDEPTH = MAX_NEURONS * (2 ** FW);

  logic [NW-1:0] nrn_q;
  logic [FW-1:0] ftr_q;

  logic [VB-1:0] w_rdata, s_rdata;

  // stage 1: RAM data out
  logic          s1_valid_q, s1_lastf_q;
  logic [NW-1:0] s1_nrn_q;
  // stage 2: absolute difference
  logic          s2_valid_q, s2_lastf_q;
  logic [NW-1:0] s2_nrn_q;
  logic [VB-1:0] absd_q;
  // stage 3: finished distance of one neuron
  logic          s3_valid_q;
  logic [NW-1:0] s3_nrn_q;
  logic [DW-1:0] dist_q, acc_q, acc_sum;
  // running minimum
  logic          best_valid_q;
  logic [DW-1:0] best_q;
  logic [NW-1:0] best_nrn_q;

  logic signed [VB:0] diff, mag;

  logic [WINNER_BITS-1:0] winner_q;
  logic [DIST_BITS-1:0]   min_distance_q;

  som_bmu_ram #(
    .WIDTH (VB),
    .DEPTH (WDEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_weight),
    .waddr_i ({NW'(item_ni_i), FW'(item_fi_i)}),
    .wdata_i (item_value_i),
    .raddr_i ({nrn_q, ftr_q}),
    .rdata_o (w_rdata)
  );

  som_bmu_ram #(
    .WIDTH (VB),
    .DEPTH (MAX_FEATURES)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_sample),
    .waddr_i (FW'(item_fi_i)),
    .wdata_i (item_value_i),
    .raddr_i (ftr_q),
    .rdata_o (s_rdata)
  );

  assign status_o.last_feature = (ftr_q == feature_last_i);
  assign status_o.last_neuron  = (nrn_q == neuron_last_i);
  assign status_o.busy         = s1_valid_q || s2_valid_q || s3_valid_q;

  assign diff    = $signed({s_rdata[VB-1], s_rdata}) - $signed({w_rdata[VB-1], w_rdata});
  assign mag     = diff[VB] ? -diff : diff;
  assign acc_sum = acc_q + DW'(absd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrn_q        <= '0;
      ftr_q        <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      best_valid_q <= 1'b0;
      acc_q        <= '0;
    end else begin
      // walk features fastest, then neurons
      if (cmd_i.start) begin
        nrn_q <= '0;
        ftr_q <= '0;
      end else if (cmd_i.step) begin
        if (status_o.last_feature) begin
          ftr_q <= '0;
          nrn_q <= nrn_q + 1'b1;
        end else begin
          ftr_q <= ftr_q + 1'b1;
        end
      end

      s1_valid_q <= cmd_i.step;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q && s2_lastf_q;

      if (cmd_i.start) begin
        acc_q <= '0;
      end else if (s2_valid_q) begin
        acc_q <= s2_lastf_q ? '0 : acc_sum;
      end

      // strict compare keeps the lowest index on ties
      if (cmd_i.start) begin
        best_valid_q <= 1'b0;
      end else if (s3_valid_q && (!best_valid_q || dist_q < best_q)) begin
        best_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_lastf_q <= status_o.last_feature;
    s1_nrn_q   <= nrn_q;
    s2_lastf_q <= s1_lastf_q;
    s2_nrn_q   <= s1_nrn_q;
    absd_q     <= mag[VB-1:0];
    if (s2_valid_q && s2_lastf_q) begin
      dist_q   <= acc_sum;
      s3_nrn_q <= s2_nrn_q;
    end
    if (s3_valid_q && (!best_valid_q || dist_q < best_q)) begin
      best_q     <= dist_q;
      best_nrn_q <= s3_nrn_q;
    end
    if (cmd_i.load_out) begin
      winner_q <= WINNER_BITS'(best_nrn_q);
      if (CW'(best_q) > CW'(DIST_MAX)) begin
        min_distance_q <= DIST_MAX;
      end else begin
        min_distance_q <= DIST_BITS'(best_q);
      end
    end
  end

  assign winner_o       = winner_q;
  assign min_distance_o = min_distance_q;

endmodule

### rtl/som_best_matching_unit_l1.sv
// Weight writes and samples that do not close a vector only write the RAMs.
// A sample closing the vector starts a search that does one weight-RAM
// read and one accumulation per cycle, then drains the pipeline and loads
// the result into the output register.
// The next item is taken once the result is loaded into the output register.
// rst_ni clears control state and reloads the counts (100 neurons, 118 features).
module som_best_matching_unit_l1 import som_bmu_pkg::*; #(
  parameter int MAX_NEURONS  = MAX_NEURONS_DEF,
  parameter int MAX_FEATURES = MAX_FEATURES_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  som_bmu_item_if.sink        item_i,
  som_bmu_result_if.source    result_o,
  som_bmu_cfg_if.sink         cfg_i
);

  localparam int NW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [NW-1:0] neuron_last;
  logic [FW-1:0] feature_last;

  som_bmu_ctrl #(
    .MAX_NEURONS  (MAX_NEURONS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_ready_o    (cfg_i.ready),
    .cfg_index_i    (cfg_i.reg_index),
    .cfg_data_i     (cfg_i.wdata),
    .item_valid_i   (item_i.valid),
    .item_ready_o   (item_i.ready),
    .item_op_i      (item_i.operation),
    .item_ni_i      (item_i.neuron_index),
    .item_fi_i      (item_i.feature_index),
    .result_valid_o (result_o.valid),
    .result_ready_i (result_o.ready),
    .cmd_o          (cmd),
    .status_i       (status),
    .neuron_last_o  (neuron_last),
    .feature_last_o (feature_last)
  );

  som_bmu_datapath #(
    .MAX_NEURONS  (MAX_NEURONS),
    .MAX_FEATURES (MAX_FEATURES),
    .VALUE_BITS   (VALUE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .neuron_last_i  (neuron_last),
    .feature_last_i (feature_last),
    .item_ni_i      (item_i.neuron_index),
    .item_fi_i      (item_i.feature_index),
    .item_value_i   (item_i.value),
    .winner_o       (result_o.winner),
    .min_distance_o (result_o.min_distance)
  );

endmodule

### rtl/som_bmu_checker.sv
`include "assert_macros.svh"

module som_bmu_checker import som_bmu_pkg::*; #(
  parameter int MAX_NEURONS = MAX_NEURONS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   item_valid_i,
  input logic                   item_ready_i,
  input logic                   item_op_i,
  input logic                   result_valid_i,
  input logic                   result_ready_i,
  input logic [WINNER_BITS-1:0] winner_i,
  input logic [DIST_BITS-1:0]   min_distance_i
);

  // A stalled word holds.
  `SOM_ASSERT_NEXT(a_result_hold, result_valid_i && !result_ready_i, result_valid_i && $stable(winner_i) && $stable(min_distance_i), "result word changed while stalled")

  // A result only appears after a search that held off the input side.
  `SOM_ASSERT_ALWAYS(a_result_after_search, $rose(result_valid_i) |-> $past(!item_ready_i), "result rose without a preceding search")

  // A weight write never starts a search.
  `SOM_ASSERT_NEXT(a_weight_no_result, item_valid_i && item_ready_i && (item_op_i == OP_WEIGHT), !$rose(result_valid_i), "weight write produced a result")

  // Winner lies inside the map.
  `SOM_ASSERT_ALWAYS(a_winner_range, result_valid_i |-> (32'(winner_i) < 32'(MAX_NEURONS)), "winner index beyond the map")

endmodule

bind som_best_matching_unit_l1 som_bmu_checker #(
  .MAX_NEURONS (MAX_NEURONS)
) u_som_bmu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .item_valid_i   (item_i.valid),
  .item_ready_i   (item_i.ready),
  .item_op_i      (item_i.operation),
  .result_valid_i (result_o.valid),
  .result_ready_i (result_o.ready),
  .winner_i       (result_o.winner),
  .min_distance_i (result_o.min_distance)
);
